[rtl/smkt_pkg.sv]
package smkt_pkg;

    localparam int KeyWidth = 8;
    localparam int CharWidth = 7;
    localparam int NavWidth = 4;
    localparam int ModeWidth = 2;
    localparam int InDataWidth = 16;
    localparam int OutDataWidth = 24;

    localparam logic [7:0] KEY_GESTURE_TAP = 8'd231;
    localparam logic [7:0] KEY_ALTERNATE = 8'd129;
    localparam logic [7:0] KEY_SHIFT_HI = 8'd128;
    localparam logic [7:0] KEY_SHIFT_LO = 8'd16;
    localparam logic [7:0] KEY_SYM_A = 8'd130;
    localparam logic [7:0] KEY_SYM_B = 8'd131;
    localparam logic [7:0] KEY_SYM_LO = 8'd17;
    localparam logic [7:0] KEY_DOT_HI = 8'd190;
    localparam logic [7:0] KEY_COMMA_HI = 8'd188;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ONE_SHOT = 2'd1;
    localparam logic [1:0] MODE_LOCKED = 2'd2;

    localparam logic [3:0] NAV_NONE = 4'd0;
    localparam logic [3:0] NAV_HOME = 4'd1;
    localparam logic [3:0] NAV_UP = 4'd2;
    localparam logic [3:0] NAV_PAGE_UP = 4'd3;
    localparam logic [3:0] NAV_LEFT = 4'd4;
    localparam logic [3:0] NAV_RIGHT = 4'd5;
    localparam logic [3:0] NAV_END = 4'd6;
    localparam logic [3:0] NAV_DOWN = 4'd7;
    localparam logic [3:0] NAV_PAGE_DOWN = 4'd8;

    typedef struct packed {
        logic [ModeWidth-1:0] gesture;
        logic [ModeWidth-1:0] sym;
        logic [ModeWidth-1:0] shift;
        logic [ModeWidth-1:0] alt;
    } modes_t;

    typedef struct packed {
        logic                 meta_held;
        logic                 ctrl_held;
        logic                 alt_held;
        logic                 shift_held;
        logic [KeyWidth-1:0]  scan_code;
    } press_t;

    typedef struct packed {
        modes_t               modes;
        logic                 state_changed;
        logic [NavWidth-1:0]  nav_action;
        logic [CharWidth-1:0] char_out;
        logic                 char_valid;
    } result_t;

    // Symbol table for the alternate modifier, indexed by letter position (A is 1).
    function automatic logic [7:0] alt_symbol(input logic [4:0] idx);
        logic [7:0] s;
        begin
            case (idx)
                5'd0:  s = "0";
                5'd1:  s = "&";
                5'd2:  s = "#";
                5'd3:  s = "8";
                5'd4:  s = "4";
                5'd5:  s = "1";
                5'd6:  s = "5";
                5'd7:  s = "6";
                5'd8:  s = "$";
                5'd9:  s = "%";
                5'd10: s = "!";
                5'd11: s = ":";
                5'd12: s = "'";
                5'd13: s = ";";
                5'd14: s = "?";
                5'd15: s = "\"";
                5'd16: s = "=";
                5'd17: s = "/";
                5'd18: s = "2";
                5'd19: s = "-";
                5'd20: s = "3";
                5'd21: s = ")";
                5'd22: s = "9";
                5'd23: s = "+";
                5'd24: s = "7";
                5'd25: s = "(";
                5'd26: s = "*";
                default: s = 8'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] nav_for_letter(input logic [7:0] k);
        logic [3:0] n;
        begin
            case (k)
                "E": n = NAV_HOME;
                "R": n = NAV_UP;
                "T": n = NAV_PAGE_UP;
                "D": n = NAV_LEFT;
                "G": n = NAV_RIGHT;
                "X": n = NAV_END;
                "C": n = NAV_DOWN;
                "V": n = NAV_PAGE_DOWN;
                default: n = NAV_NONE;
            endcase
            return n;
        end
    endfunction

    // Off, one-shot, locked, off; the unused code steps to one-shot.
    function automatic logic [1:0] advance_mode(input logic [1:0] m);
        logic [1:0] r;
        begin
            case (m)
                MODE_OFF:      r = MODE_ONE_SHOT;
                MODE_ONE_SHOT: r = MODE_LOCKED;
                MODE_LOCKED:   r = MODE_OFF;
                default:       r = MODE_ONE_SHOT;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/smkt_xlate.sv]
module smkt_xlate (
    input  smkt_pkg::press_t  press,
    input  smkt_pkg::modes_t  cur,
    output smkt_pkg::result_t res
);

    always_comb
    begin
        logic [7:0] k;
        logic [3:0] nav;
        logic shifted;
        logic alt_on;
        smkt_pkg::modes_t nxt;
        logic changed;

        k = press.scan_code;
        nav = smkt_pkg::NAV_NONE;
        nxt = cur;
        changed = 1'b1;
        shifted = (cur.shift != smkt_pkg::MODE_OFF) || press.shift_held;
        alt_on = (cur.alt != smkt_pkg::MODE_OFF);

        if (k == smkt_pkg::KEY_GESTURE_TAP)
        begin
            nxt.gesture = smkt_pkg::advance_mode(cur.gesture);
            k = 8'd0;
        end
        else if (k == smkt_pkg::KEY_ALTERNATE)
        begin
            nxt.alt = smkt_pkg::advance_mode(cur.alt);
            k = 8'd0;
        end
        else if (k == smkt_pkg::KEY_SHIFT_LO || k == smkt_pkg::KEY_SHIFT_HI
                 || (k == 8'd0 && press.shift_held))
        begin
            nxt.shift = smkt_pkg::advance_mode(cur.shift);
            k = 8'd0;
        end
        else if (k == smkt_pkg::KEY_SYM_LO || k == smkt_pkg::KEY_SYM_A
                 || k == smkt_pkg::KEY_SYM_B)
        begin
            nxt.sym = smkt_pkg::advance_mode(cur.sym);
            k = 8'd0;
        end
        else
        begin
            if (k >= "a" && k <= "z")
            begin
                k = k - 8'd32;
            end
            if (k >= "A" && k <= "Z")
            begin
                if (alt_on || press.alt_held)
                begin
                    // Letters A..Z sit at 65..90, so the low five bits are 1..26.
                    k = smkt_pkg::alt_symbol(k[4:0]);
                end
                else if (cur.gesture != smkt_pkg::MODE_OFF || press.meta_held)
                begin
                    nav = smkt_pkg::nav_for_letter(k);
                    k = 8'd0;
                end
                else if (cur.sym != smkt_pkg::MODE_OFF || press.ctrl_held)
                begin
                    k = {3'b000, k[4:0]};
                end
                else if (!shifted)
                begin
                    k = k + 8'd32;
                end
            end
            else if (k == "0" && !alt_on)
            begin
                k = "@";
            end
            else if (k == " " && alt_on)
            begin
                k = 8'd27;
            end
            else if (k == smkt_pkg::KEY_COMMA_HI || k == ",")
            begin
                k = alt_on ? "_" : (shifted ? "<" : ",");
            end
            else if (k == smkt_pkg::KEY_DOT_HI || k == ".")
            begin
                k = alt_on ? "|" : (shifted ? ">" : ".");
            end

            if (cur.alt == smkt_pkg::MODE_ONE_SHOT)
            begin
                nxt.alt = smkt_pkg::MODE_OFF;
            end
            if (cur.shift == smkt_pkg::MODE_ONE_SHOT)
            begin
                nxt.shift = smkt_pkg::MODE_OFF;
            end
            if (cur.sym == smkt_pkg::MODE_ONE_SHOT)
            begin
                nxt.sym = smkt_pkg::MODE_OFF;
            end
            if (cur.gesture == smkt_pkg::MODE_ONE_SHOT)
            begin
                nxt.gesture = smkt_pkg::MODE_OFF;
            end
            changed = (cur.alt == smkt_pkg::MODE_ONE_SHOT)
                   || (cur.shift == smkt_pkg::MODE_ONE_SHOT)
                   || (cur.sym == smkt_pkg::MODE_ONE_SHOT)
                   || (cur.gesture == smkt_pkg::MODE_ONE_SHOT);
        end

        res.char_valid = (k != 8'd0) && !k[7];
        res.char_out = res.char_valid ? k[6:0] : 7'd0;
        res.nav_action = nav;
        res.state_changed = changed;
        res.modes = nxt;
    end

endmodule

[rtl/sticky_modifier_key_translator.sv]
// Channel  | Dir | Width | Contents
// s_axis   | in  | 16    | one key press with held modifier flags
// m_axis   | out | 24    | translated character, navigation action and modifier states
//
// One beat in and one beat out per key press; a new press is taken every cycle
// while m_axis is not stalled. A press passes an input register, then the translation
// and the sticky modifier update, which land together in the output register.
// Reset clears both valid flags and returns every sticky modifier to off.
// A stall on m_axis holds the output register, and the input register then
// fills and drops s_axis_tready.
module sticky_modifier_key_translator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] scan_code, [8] shift_held, [9] alt_held, [10] ctrl_held,
    // [11] meta_held, [15:12] zero
    input  logic [smkt_pkg::InDataWidth-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] char_valid, [7:1] char_out, [11:8] nav_action, [12] state_changed,
    // [14:13] alt_mode, [16:15] shift_mode, [18:17] sym_mode,
    // [20:19] gesture_mode, [23:21] zero
    output logic [smkt_pkg::OutDataWidth-1:0] m_axis_tdata
);

    logic               in_valid_reg;
    smkt_pkg::press_t   in_press_reg;
    logic               out_valid_reg;
    smkt_pkg::result_t  out_res_reg;
    smkt_pkg::modes_t   modes_reg;
    smkt_pkg::result_t  res_next;
    logic               advance;
    logic               take_in;

    smkt_xlate u_xlate (
        .press (in_press_reg),
        .cur   (modes_reg),
        .res   (res_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            modes_reg <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                modes_reg <= res_next.modes;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_press_reg <= smkt_pkg::press_t'(s_axis_tdata[11:0]);
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b000, out_res_reg};

endmodule
